// ===== src/bpc_pkg.sv =====
// bpc_pkg: widths, constants and types of the barometric compensation pipeline
// no dependencies; imported by the interfaces, the config block and the top level

package bpc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEFF_W = 16;
  localparam int DT_W    = 25;
  localparam int TEMP_W  = 20;
  localparam int PRES_W  = 48;
  localparam int IDX_W   = 3;

  localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW = -20'sd1500;

  typedef enum logic [IDX_W-1:0] {
    CFG_SENS        = 3'd0,
    CFG_OFFSET      = 3'd1,
    CFG_SENS_TEMP   = 3'd2,
    CFG_OFFSET_TEMP = 3'd3,
    CFG_REF_TEMP    = 3'd4,
    CFG_TEMP_SLOPE  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] offset;
    logic [COEFF_W-1:0] sens_temp;
    logic [COEFF_W-1:0] offset_temp;
    logic [COEFF_W-1:0] ref_temp;
    logic [COEFF_W-1:0] temp_slope;
  } coeff_t;

endpackage

// ===== src/bpc_if.sv =====
// bpc_if: valid/ready channel interfaces for raw samples and compensated results
// depends on bpc_pkg for field widths

interface bpc_sample_if
  import bpc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_result_if
  import bpc_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi;
  logic signed [PRES_W-1:0] pressure_pa;

  modport source (output valid, output temp_centi, output pressure_pa, input ready);
  modport sink   (input valid, input temp_centi, input pressure_pa, output ready);
endinterface

// ===== src/baro_pressure_temp_compensation.sv =====
// baro_pressure_temp_compensation: second-order pressure/temperature compensation
// depends on bpc_pkg, bpc_if and bpc_cfg
//
// usage:
//   sample channel carries one raw pressure and one raw temperature conversion;
//   result channel carries temperature in 0.01 C and pressure in Pa.
//   six 16-bit calibration words are written through cfg_we/cfg_index/cfg_wdata
//   while no transfer is in flight; indexes above 5 are ignored.
// stages and throughput:
//   ten register stages lie between the sample transfer and the result channel;
//   one sample per cycle is taken while the result side keeps up.
//   the stage count is set by the multiplier stages (coefficient products,
//   squares and the split 24 x 40 pressure product) and the carry chains between.
// reset:
//   rst clears all stage valid bits and the calibration words to zero.
// stall:
//   a stage holds while its successor is full and stalled; empty stages
//   still fill, so the sample side is ready whenever any bubble is in the pipe.

module baro_pressure_temp_compensation
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  bpc_sample_if.sink         sample,
  bpc_result_if.source       result,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [COEFF_W-1:0] cfg_wdata
);

  localparam int NST = 10;

  coeff_t coeff;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coeff     (coeff)
  );

  logic [NST-1:0] v;
  logic [NST-1:0] adv;

  // stage advance chain, bubbles collapse
  always_comb begin
    adv[NST-1] = !v[NST-1] || result.ready;
    for (int i = NST-2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= sample.valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  assign sample.ready = adv[0];
  assign result.valid = v[NST-1];

  // stage 1: dT
  logic        [RAW_W-1:0] d1_s1;
  logic signed [DT_W-1:0]  dt_s1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_s1 <= sample.raw_pressure;
      dt_s1 <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, coeff.ref_temp, 8'b0});
    end
  end

  // stage 2: coefficient products and dT squared
  logic        [RAW_W-1:0] d1_s2;
  logic signed [41:0]      pt_s2;
  logic signed [41:0]      po_s2;
  logic signed [41:0]      ps_s2;
  logic signed [49:0]      pdd_s2;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d1_s2  <= d1_s1;
      pt_s2  <= dt_s1 * $signed({1'b0, coeff.temp_slope});
      po_s2  <= dt_s1 * $signed({1'b0, coeff.offset_temp});
      ps_s2  <= dt_s1 * $signed({1'b0, coeff.sens_temp});
      pdd_s2 <= dt_s1 * dt_s1;
    end
  end

  // stage 3: first-order temp, offset, sensitivity
  logic        [RAW_W-1:0]  d1_s3;
  logic signed [TEMP_W-1:0] temp_s3;
  logic signed [39:0]       off_s3;
  logic signed [39:0]       sens_s3;
  logic signed [TEMP_W-1:0] t2_s3;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      d1_s3   <= d1_s2;
      temp_s3 <= TEMP_W'(TEMP_REF + (pt_s2 >>> 23));
      off_s3  <= 40'($signed({8'b0, coeff.offset, 16'b0}) + (po_s2 >>> 7));
      sens_s3 <= 40'($signed({9'b0, coeff.sens, 15'b0}) + (ps_s2 >>> 8));
      t2_s3   <= $signed({1'b0, pdd_s2[49:31]});
    end
  end

  // stage 4: squares of the temperature distances
  logic signed [20:0] a_d;
  logic signed [20:0] b_d;
  logic signed [41:0] asq_d;
  logic signed [41:0] bsq_d;

  assign a_d   = 21'(temp_s3) - 21'(TEMP_REF);
  assign b_d   = 21'(temp_s3) - 21'(TEMP_LOW);
  assign asq_d = a_d * a_d;
  assign bsq_d = b_d * b_d;

  logic        [RAW_W-1:0]  d1_s4;
  logic signed [TEMP_W-1:0] temp_s4;
  logic signed [39:0]       off_s4;
  logic signed [39:0]       sens_s4;
  logic signed [TEMP_W-1:0] t2_s4;
  logic                     lo_s4;
  logic                     vlo_s4;
  logic        [35:0]       asq_s4;
  logic        [35:0]       bsq_s4;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      d1_s4   <= d1_s3;
      temp_s4 <= temp_s3;
      off_s4  <= off_s3;
      sens_s4 <= sens_s3;
      t2_s4   <= t2_s3;
      lo_s4   <= temp_s3 < TEMP_REF;
      vlo_s4  <= temp_s3 < TEMP_LOW;
      asq_s4  <= asq_d[35:0];
      bsq_s4  <= bsq_d[35:0];
    end
  end

  // stage 5: constant multiples of the squares
  logic [37:0] a5_d;
  logic [37:0] b7_d;
  logic [38:0] b11_d;

  assign a5_d  = ({2'b0, asq_s4} << 2) + {2'b0, asq_s4};
  assign b7_d  = ({2'b0, bsq_s4} << 3) - {2'b0, bsq_s4};
  assign b11_d = ({3'b0, bsq_s4} << 3) + ({3'b0, bsq_s4} << 1) + {3'b0, bsq_s4};

  logic        [RAW_W-1:0]  d1_s5;
  logic signed [TEMP_W-1:0] temp_s5;
  logic signed [39:0]       off_s5;
  logic signed [39:0]       sens_s5;
  logic signed [TEMP_W-1:0] t2_s5;
  logic                     lo_s5;
  logic                     vlo_s5;
  logic        [37:0]       a5h_s5;
  logic        [37:0]       b7_s5;
  logic        [37:0]       b11h_s5;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      d1_s5   <= d1_s4;
      temp_s5 <= temp_s4;
      off_s5  <= off_s4;
      sens_s5 <= sens_s4;
      t2_s5   <= t2_s4;
      lo_s5   <= lo_s4;
      vlo_s5  <= vlo_s4;
      a5h_s5  <= a5_d >> 1;
      b7_s5   <= b7_d;
      b11h_s5 <= b11_d[38:1];
    end
  end

  // stage 6: second-order offset and sensitivity terms
  logic        [RAW_W-1:0]  d1_s6;
  logic signed [TEMP_W-1:0] temp_s6;
  logic signed [39:0]       off_s6;
  logic signed [39:0]       sens_s6;
  logic signed [TEMP_W-1:0] t2_s6;
  logic                     lo_s6;
  logic        [38:0]       off2_s6;
  logic        [38:0]       sens2_s6;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      d1_s6    <= d1_s5;
      temp_s6  <= temp_s5;
      off_s6   <= off_s5;
      sens_s6  <= sens_s5;
      t2_s6    <= t2_s5;
      lo_s6    <= lo_s5;
      off2_s6  <= {1'b0, a5h_s5} + (vlo_s5 ? {1'b0, b7_s5} : 39'd0);
      sens2_s6 <= {2'b0, a5h_s5[37:1]} + (vlo_s5 ? {1'b0, b11h_s5} : 39'd0);
    end
  end

  // stage 7: apply low-temperature corrections
  logic        [RAW_W-1:0]  d1_s7;
  logic signed [TEMP_W-1:0] temp_s7;
  logic signed [39:0]       off_s7;
  logic signed [39:0]       sens_s7;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      d1_s7 <= d1_s6;
      if (lo_s6) begin
        temp_s7 <= temp_s6 - t2_s6;
        off_s7  <= off_s6 - $signed({1'b0, off2_s6});
        sens_s7 <= sens_s6 - $signed({1'b0, sens2_s6});
      end else begin
        temp_s7 <= temp_s6;
        off_s7  <= off_s6;
        sens_s7 <= sens_s6;
      end
    end
  end

  // stage 8: pressure product split in two partial products
  logic signed [TEMP_W-1:0] temp_s8;
  logic signed [39:0]       off_s8;
  logic        [43:0]       pplo_s8;
  logic signed [44:0]       pphi_s8;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      temp_s8 <= temp_s7;
      off_s8  <= off_s7;
      pplo_s8 <= {20'b0, d1_s7} * {24'b0, sens_s7[19:0]};
      pphi_s8 <= $signed({1'b0, d1_s7}) * $signed(sens_s7[39:20]);
    end
  end

  // stage 9: combine partial products
  logic signed [TEMP_W-1:0] temp_s9;
  logic signed [39:0]       off_s9;
  logic signed [63:0]       prod_s9;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      temp_s9 <= temp_s8;
      off_s9  <= off_s8;
      prod_s9 <= 64'($signed({pphi_s8, 20'b0}) + $signed({21'b0, pplo_s8}));
    end
  end

  // stage 10: output register
  logic signed [43:0] p_d;

  assign p_d = 44'((prod_s9 >>> 21) - off_s9);

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      result.temp_centi  <= temp_s9;
      result.pressure_pa <= PRES_W'(p_d >>> 15);
    end
  end

endmodule

// ===== src/bpc_cfg.sv =====
// bpc_cfg: calibration coefficient registers behind a plain write port
// depends on bpc_pkg for coeff_t and register indexes

module bpc_cfg
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [COEFF_W-1:0] cfg_wdata,
  output coeff_t             coeff
);

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SENS:        coeff.sens        <= cfg_wdata;
        CFG_OFFSET:      coeff.offset      <= cfg_wdata;
        CFG_SENS_TEMP:   coeff.sens_temp   <= cfg_wdata;
        CFG_OFFSET_TEMP: coeff.offset_temp <= cfg_wdata;
        CFG_REF_TEMP:    coeff.ref_temp    <= cfg_wdata;
        CFG_TEMP_SLOPE:  coeff.temp_slope  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/bpc_chk.sv =====
// bpc_chk: port-level checks of the compensation pipeline handshake and reset
// depends on bpc_pkg; attached to baro_pressure_temp_compensation by the bind below

module bpc_chk
  import bpc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     sample_valid,
  input logic                     sample_ready,
  input logic                     result_valid,
  input logic                     result_ready,
  input logic signed [TEMP_W-1:0] temp_centi,
  input logic signed [PRES_W-1:0] pressure_pa
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // a free output frees the whole pipe
  a_ready_through: assert property (@(posedge clk) result_ready |-> sample_ready)
    else $error("sample side stalled while result side is ready");

  // an empty output stage always leaves room
  a_empty_ready: assert property (@(posedge clk) !result_valid |-> sample_ready)
    else $error("sample side stalled with empty output stage");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      result_valid && !result_ready |=>
        result_valid && $stable(temp_centi) && $stable(pressure_pa))
    else $error("stalled result changed");

endmodule

bind baro_pressure_temp_compensation bpc_chk u_bpc_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .temp_centi   (result.temp_centi),
  .pressure_pa  (result.pressure_pa)
);

// ===== dv/baro_pressure_temp_compensation_tb.sv =====
// self-checking testbench for baro_pressure_temp_compensation
// needs bpc_pkg, bpc_if and the block; a directed table, then randomized phases under idling
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_tb;
  import bpc_pkg::*;

  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam logic [RAW_W-1:0] RAW_MAX      = 24'hFFFFFF;
  localparam logic [COEFF_W-1:0] COEFF_MAX  = 16'hFFFF;
  localparam int N_DIRECTED = 35;
  localparam int N_PHASES   = 8;
  localparam int PHASE_ITEMS = 169;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi;
    logic signed [PRES_W-1:0] pressure_pa;
  } reading_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [IDX_W-1:0] index;
    logic [RAW_W-1:0] d1;
    logic [RAW_W-1:0] d2;
    logic             typed;
    reading_t         fixed;
  } dir_row_t;

  localparam reading_t AT_RESET = '{20'sd2000, 48'sd0};
  localparam reading_t UNIT_SENS = '{20'sd2000, 48'sd7};
  localparam reading_t NONE = '{20'sd0, 48'sd0};

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_SAMPLE, CFG_SENS, 24'd0, 24'd0, 1'b1, AT_RESET},
    '{ROW_SAMPLE, CFG_SENS, RAW_MAX, RAW_MAX, 1'b1, AT_RESET},
    '{ROW_SAMPLE, CFG_SENS, RAW_MAX, 24'd0, 1'b1, AT_RESET},
    '{ROW_CFG, IDX_SPARE_LO, 24'hFFFF, 24'd0, 1'b0, NONE},
    '{ROW_CFG, IDX_SPARE_HI, 24'hFFFF, 24'd0, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'h123456, 24'h800000, 1'b1, AT_RESET},
    '{ROW_CFG, CFG_SENS, 24'd1, 24'd0, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, RAW_MAX, 24'd0, 1'b1, UNIT_SENS},
    '{ROW_CFG, CFG_SENS, 24'd40127, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_OFFSET, 24'd36924, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_SENS_TEMP, 24'd23317, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_OFFSET_TEMP, 24'd23282, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_REF_TEMP, 24'd33464, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_TEMP_SLOPE, 24'd28312, 24'd0, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd9085466, 24'd8569150, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd9085466, 24'd8000000, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd9085466, 24'd7000000, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd0, 24'd0, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, RAW_MAX, RAW_MAX, 1'b0, NONE},
    // slope 2^15 and reference 0x8000: temperature is 2000 + (dT >> 8)
    '{ROW_CFG, CFG_REF_TEMP, 24'd32768, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_TEMP_SLOPE, 24'd32768, 24'd0, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd9085466, 24'd8388608, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd9085466, 24'd8388607, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd9085466, 24'd7492608, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd9085466, 24'd7492607, 1'b0, NONE},
    '{ROW_CFG, CFG_SENS, 24'hFFFF, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_OFFSET, 24'hFFFF, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_SENS_TEMP, 24'hFFFF, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_OFFSET_TEMP, 24'hFFFF, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_REF_TEMP, 24'hFFFF, 24'd0, 1'b0, NONE},
    '{ROW_CFG, CFG_TEMP_SLOPE, 24'hFFFF, 24'd0, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd0, 24'd0, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, RAW_MAX, RAW_MAX, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, RAW_MAX, 24'd0, 1'b0, NONE},
    '{ROW_SAMPLE, CFG_SENS, 24'd0, RAW_MAX, 1'b0, NONE}
  };

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [COEFF_W-1:0] cfg_wdata;

  bpc_sample_if sample_ch();
  bpc_result_if result_ch();

  baro_pressure_temp_compensation dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  coeff_t     cal;
  reading_t   pending_readings[$];
  int         mismatches = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  logic       row_typed;
  reading_t   row_reading;

  function automatic reading_t compensate(input coeff_t k, input logic [RAW_W-1:0] d1_raw,
                                          input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, a, off2, sens2, b, sq, p;
    reading_t r;
    d1 = {40'd0, d1_raw};
    d2 = {40'd0, d2_raw};
    c1 = {48'd0, k.sens};
    c2 = {48'd0, k.offset};
    c3 = {48'd0, k.sens_temp};
    c4 = {48'd0, k.offset_temp};
    c5 = {48'd0, k.ref_temp};
    c6 = {48'd0, k.temp_slope};
    dt = d2 - c5 * 256;
    temp = TEMP_REF + ((dt * c6) >>> 23);
    off = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    if (temp < TEMP_REF) begin
      t2 = (dt * dt) >>> 31;
      a = temp - TEMP_REF;
      off2 = (5 * (a * a)) >>> 1;
      sens2 = off2 >>> 1;
      // extra cold correction
      if (temp < TEMP_LOW) begin
        b = temp - TEMP_LOW;
        sq = b * b;
        off2 += 7 * sq;
        sens2 += (11 * sq) >>> 1;
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
    end
    p = ((d1 * sens) >>> 21) - off;
    p = p >>> 15;
    r.temp_centi = temp[TEMP_W-1:0];
    r.pressure_pa = p[PRES_W-1:0];
    return r;
  endfunction

  function automatic int gap_pct();
    case (idle_mode)
      IDLE_SEND: return 47;
      IDLE_BOTH: return 20;
      default:   return 0;
    endcase
  endfunction

  function automatic int stall_pct();
    case (idle_mode)
      IDLE_RECV: return 47;
      IDLE_BOTH: return 20;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return COEFF_MAX;
    return COEFF_W'($urandom);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample transfers are predicted with the calibration in force at that edge
  always @(posedge clk) begin
    if (rst) begin
      cal = '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        if (row_typed) pending_readings.push_back(row_reading);
        else pending_readings.push_back(compensate(cal, sample_ch.raw_pressure,
                                                   sample_ch.raw_temperature));
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SENS:        cal.sens = cfg_wdata;
          CFG_OFFSET:      cal.offset = cfg_wdata;
          CFG_SENS_TEMP:   cal.sens_temp = cfg_wdata;
          CFG_OFFSET_TEMP: cal.offset_temp = cfg_wdata;
          CFG_REF_TEMP:    cal.ref_temp = cfg_wdata;
          CFG_TEMP_SLOPE:  cal.temp_slope = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    reading_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result temp_centi %0d pressure_pa %0d", $time,
                 result_ch.temp_centi, result_ch.pressure_pa);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (result_ch.temp_centi !== want.temp_centi) begin
          $display("%0t: temp_centi expected %0d actual %0d", $time, want.temp_centi,
                   result_ch.temp_centi);
          mismatches++;
        end
        if (result_ch.pressure_pa !== want.pressure_pa) begin
          $display("%0t: pressure_pa expected %0d actual %0d", $time, want.pressure_pa,
                   result_ch.pressure_pa);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) result_ch.ready <= ($urandom_range(99) >= stall_pct());

  task automatic push_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                             input logic typed, input reading_t fixed);
    while ($urandom_range(99) < gap_pct()) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.raw_pressure <= d1;
    sample_ch.raw_temperature <= d2;
    row_typed <= typed;
    row_reading <= fixed;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEFF_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_cal(input coeff_t k);
    write_reg(CFG_SENS, k.sens);
    write_reg(CFG_OFFSET, k.offset);
    write_reg(CFG_SENS_TEMP, k.sens_temp);
    write_reg(CFG_OFFSET_TEMP, k.offset_temp);
    write_reg(CFG_REF_TEMP, k.ref_temp);
    write_reg(CFG_TEMP_SLOPE, k.temp_slope);
  endtask

  initial begin : stimulus
    coeff_t           k;
    logic [RAW_W-1:0] d1;
    logic [RAW_W-1:0] d2;
    int               center;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.raw_pressure <= '0;
    sample_ch.raw_temperature <= '0;
    row_typed <= 1'b0;
    row_reading <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].index, directed_rows[i].d1[COEFF_W-1:0]);
      else
        push_sample(directed_rows[i].d1, directed_rows[i].d2, directed_rows[i].typed,
                    directed_rows[i].fixed);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 0) k = '0;
      else if (ph == 1) k = '1;
      else k = '{pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                 pick_coeff()};
      write_cal(k);
      idle_mode = idle_mode_t'(ph % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(15))
          0:       d1 = '0;
          1:       d1 = RAW_MAX;
          default: d1 = RAW_W'($urandom);
        endcase
        // half the temperatures land near the reference point, reaching the cold branches
        if ($urandom_range(1) == 0) begin
          d2 = RAW_W'($urandom);
        end else begin
          center = int'(cal.ref_temp) * 256 + int'($urandom_range(1 << 22)) - (1 << 21);
          if (center < 0) center = 0;
          if (center > int'(RAW_MAX)) center = int'(RAW_MAX);
          d2 = RAW_W'(center);
        end
        push_sample(d1, d2, 1'b0, NONE);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
